// ===== rtl/core/rau_pkg.sv =====
package rau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int MAG_W = DATA_WIDTH;
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int SUM_W = PROD_W + 1;
  localparam int CNT_W = $clog2(SUM_W + 1);

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_EQ = 3'd4;
  localparam logic [2:0] CMD_LT = 3'd5;
  localparam logic [2:0] CMD_GT = 3'd6;
  localparam logic [2:0] CMD_NONE = 3'd7;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  typedef struct packed {
    logic [2:0] cmd;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic truth;
    logic [1:0] status;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic combine;
    logic gcd_start;
    logic gcd_step;
    logic div_start;
    logic div_step;
    logic scale_start;
    logic scale_next;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic early;
    logic gcd_done;
    logic div_done;
  } dp_stat_t;

endpackage

// ===== rtl/core/rau_if.sv =====
interface rau_in_if;
  logic valid;
  logic ready;
  rau_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rau_out_if;
  logic valid;
  logic ready;
  rau_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/rau_datapath.sv =====
module rau_datapath (
  input  logic clk,
  input  rau_pkg::in_item_t in_item,
  input  rau_pkg::dp_cmd_t cmd_i,
  output rau_pkg::dp_stat_t stat_o,
  output rau_pkg::out_item_t res_o
);

  localparam int W = rau_pkg::DATA_WIDTH;
  localparam int PW = rau_pkg::PROD_W;
  localparam int SW = rau_pkg::SUM_W;

  logic [2:0] cmd_r;
  logic [W-1:0] an_r, ad_r, bn_r, bd_r;
  logic sa_r, sb_r;
  logic [PW-1:0] p1_r, p2_r, p3_r;
  logic [SW-1:0] nmag_r, den_r;
  logic nneg_r;
  logic truth_r;
  logic [1:0] st_r;
  logic early_r;
  // gcd registers
  logic [SW-1:0] gx_r, gy_r;
  // divider registers
  logic [SW-1:0] dq_r, drem_r, dvd_r;
  logic [rau_pkg::CNT_W-1:0] dcnt_r;
  logic dsel_r;
  logic [SW-1:0] qn_r;
  rau_pkg::out_item_t res_r;
  rau_pkg::out_item_t res_nxt;

  // Magnitude of the low W bits of a field.
  function automatic logic [W-1:0] mag_of(input logic [31:0] v);
    logic [W-1:0] x;
    x = v[W-1:0];
    return x[W-1] ? (~x + 1'b1) : x;
  endfunction

  logic [W-1:0] an_m, ad_m, bn_m, bd_m;
  logic an_s, ad_s, bn_s, bd_s;
  logic zero_den;
  always_comb begin
    an_m = mag_of(in_item.a_num);
    ad_m = mag_of(in_item.a_den);
    bn_m = mag_of(in_item.b_num);
    bd_m = mag_of(in_item.b_den);
    an_s = in_item.a_num[W-1];
    ad_s = in_item.a_den[W-1];
    bn_s = in_item.b_num[W-1];
    bd_s = in_item.b_den[W-1];
    zero_den = (ad_m == '0) || (bd_m == '0) ||
               ((in_item.cmd == rau_pkg::CMD_DIV) && (bn_m == '0));
  end

  // Shared multiplier, operands chosen by step.
  logic [W-1:0] ma, mb;
  logic [PW-1:0] mp;
  always_comb begin
    if (cmd_i.mul2) begin
      ma = (cmd_r == rau_pkg::CMD_DIV) ? ad_r : an_r;
      mb = bn_r;
    end else begin
      ma = an_r;
      mb = bd_r;
    end
    mp = PW'(ma) * PW'(mb);
  end

  // Combine step: signed magnitude sum and comparisons.
  logic [SW-1:0] pm, qm, smag;
  logic pn, qn, sneg, tval;
  always_comb begin
    pm = SW'(p1_r);
    qm = SW'(p2_r);
    pn = sa_r;
    qn = ((cmd_r == rau_pkg::CMD_SUB) ? !sb_r : sb_r) && (qm != '0);
    if (pn == qn) begin
      smag = pm + qm;
      sneg = pn;
    end else if (pm >= qm) begin
      smag = pm - qm;
      sneg = pn;
    end else begin
      smag = qm - pm;
      sneg = qn;
    end
    if (smag == '0) sneg = 1'b0;
    // Comparisons on signed values l = sa*p1, r = sb*p2.
    case (cmd_r)
      rau_pkg::CMD_EQ: tval = (pm == qm) && ((sa_r == sb_r) || (pm == '0));
      rau_pkg::CMD_LT: tval = (sa_r && !sb_r) ? !((pm == '0) && (qm == '0)) :
                              (!sa_r && sb_r) ? 1'b0 :
                              sa_r ? (pm > qm) : (pm < qm);
      rau_pkg::CMD_GT: tval = (!sa_r && sb_r) ? !((pm == '0) && (qm == '0)) :
                              (sa_r && !sb_r) ? 1'b0 :
                              sa_r ? (pm < qm) : (pm > qm);
      default: tval = 1'b0;
    endcase
  end

  // One restoring division step. The divisor is the current Euclid operand,
  // or the gcd while the numerator and denominator are scaled down.
  logic [SW-1:0] divisor;
  logic [SW:0] rtry;
  logic [SW-1:0] rsh;
  always_comb begin
    divisor = dsel_r ? gy_r : gx_r;
    rsh = {drem_r[SW-2:0], dvd_r[SW-1]};
    rtry = {drem_r, dvd_r[SW-1]} - {1'b0, divisor};
  end

  logic [SW-1:0] lim;
  assign lim = SW'(1) << (W - 1);

  // Result word: early outcomes pass through, reduced fractions are range checked.
  always_comb begin
    res_nxt = '0;
    res_nxt.truth = truth_r;
    res_nxt.status = st_r;
    if (!early_r) begin
      if ((dq_r > lim - SW'(1)) || (nneg_r ? (qn_r > lim) : (qn_r > lim - SW'(1)))) begin
        res_nxt.status = rau_pkg::ST_OVF;
      end else begin
        res_nxt.res_num = 32'(nneg_r ? (SW'(0) - qn_r) : qn_r);
        res_nxt.res_den = 31'(dq_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r <= in_item.cmd;
      an_r <= an_m;
      ad_r <= ad_m;
      bn_r <= bn_m;
      bd_r <= bd_m;
      sa_r <= (an_s != ad_s) && (an_m != '0);
      sb_r <= (bn_s != bd_s) && (bn_m != '0);
      truth_r <= 1'b0;
      early_r <= (in_item.cmd == rau_pkg::CMD_NONE) || zero_den;
      st_r <= ((in_item.cmd != rau_pkg::CMD_NONE) && zero_den) ? rau_pkg::ST_ZERO :
                                                                  rau_pkg::ST_OK;
    end
    // p1 = an*bd, p2 = bn*ad (div: an*bd, ad*bn); p3 = den; mul: p1 = an*bn.
    if (cmd_i.mul1) begin
      p1_r <= mp;
      p3_r <= PW'(ad_r) * PW'((cmd_r == rau_pkg::CMD_DIV) ? bn_r : bd_r);
    end
    if (cmd_i.mul2) begin
      p2_r <= (cmd_r == rau_pkg::CMD_DIV) ? mp : PW'(bn_r) * PW'(ad_r);
      if (cmd_r == rau_pkg::CMD_MUL) p1_r <= PW'(an_r) * PW'(bn_r);
    end
    if (cmd_i.combine) begin
      den_r <= SW'(p3_r);
      if (cmd_r >= rau_pkg::CMD_EQ) begin
        truth_r <= tval;
        early_r <= 1'b1;
      end else if (cmd_r == rau_pkg::CMD_MUL || cmd_r == rau_pkg::CMD_DIV) begin
        nmag_r <= SW'(p1_r);
        nneg_r <= (sa_r != sb_r) && (p1_r != '0);
      end else begin
        nmag_r <= smag;
        nneg_r <= sneg;
      end
    end
    // Euclid: each remainder found by the serial divider.
    if (cmd_i.gcd_start) begin
      gx_r <= den_r;
      gy_r <= nmag_r;
    end
    if (cmd_i.gcd_step) begin
      gy_r <= gx_r;
      gx_r <= drem_r;
    end
    // Serial divider: Euclid remainders, then numerator and denominator over the gcd.
    if (cmd_i.div_start) begin
      dsel_r <= 1'b0;
      dvd_r <= gy_r;
      drem_r <= '0;
      dq_r <= '0;
      dcnt_r <= rau_pkg::CNT_W'(SW);
    end else if (cmd_i.scale_start) begin
      dsel_r <= 1'b1;
      dvd_r <= nmag_r;
      drem_r <= '0;
      dq_r <= '0;
      dcnt_r <= rau_pkg::CNT_W'(SW);
    end else if (cmd_i.scale_next) begin
      qn_r <= dq_r;
      dvd_r <= den_r;
      drem_r <= '0;
      dq_r <= '0;
      dcnt_r <= rau_pkg::CNT_W'(SW);
    end else if (cmd_i.div_step) begin
      dvd_r <= {dvd_r[SW-2:0], 1'b0};
      if (!rtry[SW]) begin
        drem_r <= rtry[SW-1:0];
        dq_r <= {dq_r[SW-2:0], 1'b1};
      end else begin
        drem_r <= rsh;
        dq_r <= {dq_r[SW-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 1'b1;
    end
    if (cmd_i.finish) begin
      res_r <= res_nxt;
    end
  end

  assign stat_o.early = early_r;
  assign stat_o.gcd_done = (gx_r == '0);
  assign stat_o.div_done = (dcnt_r == '0);
  assign res_o = res_r;

endmodule

// ===== rtl/core/rau_ctrl.sv =====
module rau_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  rau_pkg::dp_stat_t stat_i,
  output rau_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CHECK  = 10'b0000000010,
    S_MUL1   = 10'b0000000100,
    S_MUL2   = 10'b0000001000,
    S_COMB   = 10'b0000010000,
    S_START  = 10'b0000100000,
    S_GCD    = 10'b0001000000,
    S_DIV    = 10'b0010000000,
    S_SCALE  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic ovalid_r, ovalid_nxt;
  logic scale_phase_r, scale_phase_nxt;

  // The result register parts the sides, so a new transaction may start
  // while the previous result still waits.
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = ovalid_r;

  // Sequencer: check, multiply, combine, Euclid loop, scale, deliver; early outcomes skip to deliver.
  always_comb begin
    state_nxt = state_r;
    ovalid_nxt = ovalid_r;
    scale_phase_nxt = scale_phase_r;
    cmd_o = '0;
    if (out_ready) ovalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd_o.load = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: state_nxt = stat_i.early ? S_DONE : S_MUL1;
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_nxt = S_COMB;
      end
      S_COMB: begin
        cmd_o.combine = 1'b1;
        state_nxt = S_START;
      end
      S_START: begin
        cmd_o.gcd_start = 1'b1;
        state_nxt = S_GCD;
        if (stat_i.early) state_nxt = S_DONE;
      end
      S_GCD: begin
        if (stat_i.gcd_done) begin
          cmd_o.scale_start = 1'b1;
          scale_phase_nxt = 1'b0;
          state_nxt = S_SCALE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.gcd_step = 1'b1;
          state_nxt = S_GCD;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      // Numerator over the gcd first, then the denominator.
      S_SCALE: begin
        if (stat_i.div_done) begin
          if (!scale_phase_r) begin
            cmd_o.scale_next = 1'b1;
            scale_phase_nxt = 1'b1;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_DONE: begin
        if (!ovalid_r || out_ready) begin
          cmd_o.finish = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
      scale_phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
      scale_phase_r <= scale_phase_nxt;
    end
  end

endmodule

// ===== rtl/core/rational_arithmetic_unit_core.sv =====
// Channel  Dir  Payload                                    Handshake
// in       in   cmd, a_num, a_den, b_num, b_den             in.valid / in.ready
// out      out  res_num, res_den, truth, status             out.valid / out.ready
//
// A transaction is taken only while the sequencer is idle. Its result is offered
// after the check for a zero denominator or the unused code, after the multiply
// and combine states for a comparison, and for arithmetic after a Euclid loop
// of one or more steps, each a bit-serial remainder plus control states, and the
// scaling of numerator and denominator by the gcd. The divider sets the rate.
// Reset clears the sequencer and the output valid. A stalled result is held in
// its register while the next transaction is worked on; that one waits at the end.
module rational_arithmetic_unit_core (
  input logic clk,
  input logic rst_n,
  rau_in_if.sink in_ch,
  rau_out_if.source out_ch
);

  rau_pkg::dp_cmd_t dp_cmd;
  rau_pkg::dp_stat_t dp_stat;

  rau_ctrl u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat_i(dp_stat),
    .cmd_o(dp_cmd)
  );

  rau_datapath u_dp (
    .clk(clk),
    .in_item(in_ch.data),
    .cmd_i(dp_cmd),
    .stat_o(dp_stat),
    .res_o(out_ch.data)
  );

endmodule

// ===== rtl/core/rau_checker.sv =====
module rau_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_status,
  input logic [30:0] out_res_den,
  input logic out_truth
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // A stalled result keeps its status, denominator and truth flag.
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_res_den) &&
    $stable(out_truth)) else $error("pending result changed");

  // Error results carry zero denominator and a clear truth flag.
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rau_pkg::ST_OK |-> out_res_den == '0 && !out_truth)
    else $error("error result not cleared");

  // The status is always one of the defined codes.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == rau_pkg::ST_OK || out_status == rau_pkg::ST_ZERO ||
    out_status == rau_pkg::ST_OVF) else $error("bad status");

endmodule

bind rational_arithmetic_unit_core rau_checker u_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_status(out_ch.data.status),
  .out_res_den(out_ch.data.res_den),
  .out_truth(out_ch.data.truth)
);

// ===== verif/tb_rational_arithmetic_unit_core.sv =====
module tb_rational_arithmetic_unit_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;

  rau_in_if in_ch ();
  rau_out_if out_ch ();

  rational_arithmetic_unit_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  rau_pkg::in_item_t pending_q[$];
  rau_pkg::out_item_t expected_q[$];
  int errors = 0;
  bit stim_done = 0;
  int hold_cycles = 0;

  // Split a two's complement word into sign and magnitude.
  function automatic void split_word(input logic [31:0] w, output bit neg,
                                     output logic [63:0] mag);
    neg = w[31];
    mag = neg ? {32'd0, (~w + 32'd1)} : {32'd0, w};
  endfunction

  function automatic logic [63:0] euclid_gcd(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Work out the reduced fraction or comparison outcome for one transaction.
  function automatic rau_pkg::out_item_t rational_result(input rau_pkg::in_item_t it);
    rau_pkg::out_item_t r;
    bit an_s, ad_s, bn_s, bd_s, sa, sb, pn, qn, nn;
    logic [63:0] an, ad, bn, bd, pm, qm, nm, den, g;
    logic signed [64:0] lv, rv;
    r = '0;
    split_word(it.a_num, an_s, an);
    split_word(it.a_den, ad_s, ad);
    split_word(it.b_num, bn_s, bn);
    split_word(it.b_den, bd_s, bd);
    sa = (an_s != ad_s) && an != 0;
    sb = (bn_s != bd_s) && bn != 0;
    if (it.cmd == rau_pkg::CMD_NONE) return r;
    if (ad == 0 || bd == 0 || (it.cmd == rau_pkg::CMD_DIV && bn == 0)) begin
      r.status = rau_pkg::ST_ZERO;
      return r;
    end
    if (it.cmd >= rau_pkg::CMD_EQ) begin
      lv = $signed({1'b0, an * bd});
      rv = $signed({1'b0, bn * ad});
      if (sa) lv = -lv;
      if (sb) rv = -rv;
      case (it.cmd)
        rau_pkg::CMD_EQ: r.truth = (lv == rv);
        rau_pkg::CMD_LT: r.truth = (lv < rv);
        default: r.truth = (lv > rv);
      endcase
      return r;
    end
    if (it.cmd == rau_pkg::CMD_ADD || it.cmd == rau_pkg::CMD_SUB) begin
      pn = sa;
      pm = an * bd;
      qm = bn * ad;
      qn = (it.cmd == rau_pkg::CMD_SUB) ? !sb : sb;
      if (qm == 0) qn = 0;
      if (pn == qn) begin
        nn = pn;
        nm = pm + qm;
      end else if (pm >= qm) begin
        nn = pn;
        nm = pm - qm;
      end else begin
        nn = qn;
        nm = qm - pm;
      end
      if (nm == 0) nn = 0;
      den = ad * bd;
    end else if (it.cmd == rau_pkg::CMD_MUL) begin
      nm = an * bn;
      nn = (sa != sb) && nm != 0;
      den = ad * bd;
    end else begin
      nm = an * bd;
      nn = (sa != sb) && nm != 0;
      den = ad * bn;
    end
    g = euclid_gcd(nm, den);
    nm = nm / g;
    den = den / g;
    if (den > 64'h7FFF_FFFF || (nn ? nm > 64'h8000_0000 : nm > 64'h7FFF_FFFF)) begin
      r.status = rau_pkg::ST_OVF;
      return r;
    end
    r.res_num = nn ? (32'd0 - nm[31:0]) : nm[31:0];
    r.res_den = den[30:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 20);
      2: return -$urandom_range(1, 20);
      3: return $urandom_range(0, 65535);
      4: return -$urandom_range(1, 65535);
      default: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic rau_pkg::in_item_t make_item(input logic [2:0] c,
                                                  input logic [31:0] an,
                                                  input logic [31:0] ad,
                                                  input logic [31:0] bn,
                                                  input logic [31:0] bd);
    rau_pkg::in_item_t it;
    it.cmd = c;
    it.a_num = an;
    it.a_den = ad;
    it.b_num = bn;
    it.b_den = bd;
    return it;
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Reset, directed cases and random transactions.
  initial begin
    rau_pkg::in_item_t it;
    rst_n = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    for (int c = 0; c < 8; c++)
      pending_q.push_back(make_item(c[2:0], 32'd3, 32'd4, -32'd5, 32'd6));
    pending_q.push_back(make_item(rau_pkg::CMD_ADD, 32'd1, 32'd2, -32'd1, 32'd2));
    pending_q.push_back(make_item(rau_pkg::CMD_DIV, 32'd1, 32'd2, 32'd0, 32'd3));
    pending_q.push_back(make_item(rau_pkg::CMD_ADD, 32'd1, 32'd0, 32'd1, 32'd3));
    pending_q.push_back(make_item(rau_pkg::CMD_MUL, 32'd1, 32'd3, 32'd1, 32'd0));
    pending_q.push_back(make_item(rau_pkg::CMD_EQ, 32'd2, 32'd4, 32'd1, 32'd2));
    pending_q.push_back(make_item(rau_pkg::CMD_LT, -32'd1, -32'd2, 32'd1, 32'd2));
    pending_q.push_back(make_item(rau_pkg::CMD_GT, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF,
                                  32'd1));
    pending_q.push_back(make_item(rau_pkg::CMD_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000,
                                  32'd1));
    pending_q.push_back(make_item(rau_pkg::CMD_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'd1));
    pending_q.push_back(make_item(rau_pkg::CMD_DIV, 32'd1, 32'h8000_0000, 32'd1, 32'd1));
    pending_q.push_back(make_item(rau_pkg::CMD_DIV, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h8000_0000, 32'h7FFF_FFFF));
    pending_q.push_back(make_item(rau_pkg::CMD_SUB, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF,
                                  32'd1));
    pending_q.push_back(make_item(rau_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
                                  32'd7));
    pending_q.push_back(make_item(rau_pkg::CMD_SUB, 32'd0, 32'd5, 32'd0, -32'd9));
    for (int i = 0; i < 1700; i++) begin
      it.cmd = ($urandom_range(0, 30) == 0) ? rau_pkg::CMD_NONE : 3'($urandom_range(0, 6));
      it.a_num = rand_word();
      it.a_den = ($urandom_range(0, 25) == 0) ? 32'd0 : rand_word();
      it.b_num = rand_word();
      it.b_den = ($urandom_range(0, 25) == 0) ? 32'd0 : rand_word();
      pending_q.push_back(it);
    end
    stim_done = 1;
  end

  // Sender: bursts of transactions separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(rational_result(in_ch.data));
        void'(pending_q.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the current transaction until it is taken.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 0;
      end else if ((pending_q.size() > (in_ch.valid && in_ch.ready ? 0 : 0))
                   && pending_q.size() > 0) begin
        in_ch.valid <= 1;
        in_ch.data <= pending_q[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off early in the run.
  int out_count = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
      hold_cycles <= 0;
    end else begin
      if (out_count == 30 && hold_cycles < 2000) begin
        hold_cycles <= hold_cycles + 1;
        out_ch.ready <= 0;
      end else if (out_count > 1000 && out_count < 1200) begin
        out_ch.ready <= 1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  rau_pkg::out_item_t exp_item;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      out_count <= out_count + 1;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, out_ch.data);
      end else begin
        exp_item = expected_q.pop_front();
        if (exp_item.res_num !== out_ch.data.res_num) begin
          errors++;
          $display("%0t: res_num expected %h actual %h", $time, exp_item.res_num,
                   out_ch.data.res_num);
        end
        if (exp_item.res_den !== out_ch.data.res_den) begin
          errors++;
          $display("%0t: res_den expected %h actual %h", $time, exp_item.res_den,
                   out_ch.data.res_den);
        end
        if (exp_item.truth !== out_ch.data.truth) begin
          errors++;
          $display("%0t: truth expected %b actual %b", $time, exp_item.truth,
                   out_ch.data.truth);
        end
        if (exp_item.status !== out_ch.data.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, exp_item.status,
                   out_ch.data.status);
        end
      end
    end
  end

  // End of run once everything has drained.
  initial begin
    wait (stim_done);
    wait (pending_q.size() == 0 && !in_ch.valid && expected_q.size() == 0);
    repeat (7000) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("rational_arithmetic_unit_core test passed");
    else
      $display("rational_arithmetic_unit_core test failed");
    $finish;
  end

  // Timeout.
  initial begin
    #1_000_000_000;
    $display("rational_arithmetic_unit_core test failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/rau_pkg.sv
rtl/core/rau_if.sv
rtl/core/rau_datapath.sv
rtl/core/rau_ctrl.sv
rtl/core/rational_arithmetic_unit_core.sv
rtl/core/rau_checker.sv
verif/tb_rational_arithmetic_unit_core.sv
